FILE: hw/rtl/pwsa_pkg.sv
// ----------------------------------------------------------------------------
// pwsa_pkg
// Shared widths, register map and reset values of the perspective warp
// source address unit.
// ----------------------------------------------------------------------------
package pwsa_pkg;

  // Configuration port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Stream payload widths.
  localparam int COORD_W     = 16;
  localparam int IN_TDATA_W  = 2 * COORD_W;
  localparam int ROW_W       = 10;
  localparam int COL_W       = 11;
  localparam int OUT_TDATA_W = 24;

  // Arithmetic widths. The projective sums fit in 50 signed bits.
  localparam int COEF_W     = 32;
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int SUM_W      = 50;
  localparam int OFF_SHIFT  = 8;   // Q16.16 offsets aligned to 24 fraction bits
  localparam int FRAC_SHIFT = 12;  // 36 - 24 fraction bits between numerator and denominator
  localparam int DEN_FRAC   = 36;

  localparam logic signed [SUM_W-1:0] DEN_ONE = SUM_W'(64'd1 << DEN_FRAC);

  // Default source image size.
  localparam int SRC_ROWS_DEF = 1024;
  localparam int SRC_COLS_DEF = 2048;

  // Register map, one register every four bytes.
  typedef enum logic [2:0] {
    REG_ROW_FROM_ROW = 3'd0,
    REG_ROW_FROM_COL = 3'd1,
    REG_ROW_OFFSET   = 3'd2,
    REG_COL_FROM_ROW = 3'd3,
    REG_COL_FROM_COL = 3'd4,
    REG_COL_OFFSET   = 3'd5,
    REG_DEN_FROM_ROW = 3'd6,
    REG_DEN_FROM_COL = 3'd7
  } reg_idx_t;

  // Identity matrix after reset.
  localparam logic [COEF_W-1:0] COEF_ONE  = 32'd16777216;
  localparam logic [COEF_W-1:0] COEF_ZERO = '0;

  typedef logic signed [SUM_W-1:0] sum_t;

endpackage

FILE: hw/rtl/perspective_warp_source_address.sv
// Throughput: one item per cycle while the result stream is not stalled.
// The restoring divider spends one stage per quotient bit, which sets the
// depth; the multipliers take one stage.
// Reset: the matrix returns to identity and the pipeline empties; payload
// registers are not reset.
// ----------------------------------------------------------------------------
// perspective_warp_source_address_unit
// Maps a panorama coordinate through the loaded inverse homography and gives
// the source row, column and inside flag, one item per clock unless stalled.
// ----------------------------------------------------------------------------
module perspective_warp_source_address_unit #(
  parameter int SRC_ROWS = pwsa_pkg::SRC_ROWS_DEF,
  parameter int SRC_COLS = pwsa_pkg::SRC_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream. in_tdata: out_row [15:0], out_col [31:16].
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pwsa_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Result stream. out_tdata: src_row [9:0], src_col [20:10], zero [23:21].
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pwsa_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: inside_res [0].
  output logic                               out_tuser,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pwsa_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pwsa_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pwsa_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import pwsa_pkg::*;

  // Quotient magnitude bits, enough for the larger image side.
  localparam int QW = $clog2(((SRC_ROWS > SRC_COLS) ? SRC_ROWS : SRC_COLS) + 1);
  // Remainder width: numerator magnitude shifted and the widest divisor shift.
  localparam int WW = SUM_W + FRAC_SHIFT + QW;
  // Stages: multiply, sum, magnitude, QW + 1 divider stages, output.
  localparam int NS = QW + 5;
  localparam int ST_DIV = 3;
  localparam logic [QW:0] ROWS_LIM = (QW+1)'(SRC_ROWS);
  localparam logic [QW:0] COLS_LIM = (QW+1)'(SRC_COLS);

  // Matrix registers.
  logic signed [COEF_W-1:0] row_from_row_r, row_from_col_r, row_offset_r;
  logic signed [COEF_W-1:0] col_from_row_r, col_from_col_r, col_offset_r;
  logic signed [COEF_W-1:0] den_from_row_r, den_from_col_r;
  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;

  // Pipeline control.
  logic [NS-1:0] stg_vld_r, stg_vld_nxt;
  logic [NS-1:0] adv;

  // Multiply stage.
  logic signed [COORD_W-1:0] in_row, in_col;
  logic signed [PROD_W-1:0]  mu_rr_r, mu_rc_r, mu_cr_r, mu_cc_r, mu_dr_r, mu_dc_r;
  logic signed [COEF_W-1:0]  mu_roff_r, mu_coff_r;

  // Sum stage.
  sum_t su_rsum_r, su_csum_r, su_dsum_r;

  // Magnitude stage.
  logic [SUM_W-1:0] ab_rmag_r, ab_cmag_r, ab_dmag_r;
  logic             ab_rneg_r, ab_cneg_r;

  // Divider stages.
  logic [WW-1:0]    dv_rrem_r [0:QW];
  logic [WW-1:0]    dv_crem_r [0:QW];
  logic [SUM_W-1:0] dv_den_r  [0:QW];
  logic [QW-1:0]    dv_rq_r   [0:QW];
  logic [QW-1:0]    dv_cq_r   [0:QW];
  logic             dv_rovf_r [0:QW];
  logic             dv_covf_r [0:QW];
  logic             dv_rneg_r [0:QW];
  logic             dv_cneg_r [0:QW];

  // Output stage.
  logic             row_in, col_in, in_img;
  logic [ROW_W-1:0] src_row_r, src_row_nxt;
  logic [COL_W-1:0] src_col_r, src_col_nxt;
  logic             inside_r;

  // Configuration writes and reads.
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_from_row_r <= COEF_ONE;
      row_from_col_r <= COEF_ZERO;
      row_offset_r   <= COEF_ZERO;
      col_from_row_r <= COEF_ZERO;
      col_from_col_r <= COEF_ONE;
      col_offset_r   <= COEF_ZERO;
      den_from_row_r <= COEF_ZERO;
      den_from_col_r <= COEF_ZERO;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROW_FROM_ROW: row_from_row_r <= pwdata;
        REG_ROW_FROM_COL: row_from_col_r <= pwdata;
        REG_ROW_OFFSET:   row_offset_r   <= pwdata;
        REG_COL_FROM_ROW: col_from_row_r <= pwdata;
        REG_COL_FROM_COL: col_from_col_r <= pwdata;
        REG_COL_OFFSET:   col_offset_r   <= pwdata;
        REG_DEN_FROM_ROW: den_from_row_r <= pwdata;
        REG_DEN_FROM_COL: den_from_col_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROW_FROM_ROW: prdata = row_from_row_r;
      REG_ROW_FROM_COL: prdata = row_from_col_r;
      REG_ROW_OFFSET:   prdata = row_offset_r;
      REG_COL_FROM_ROW: prdata = col_from_row_r;
      REG_COL_FROM_COL: prdata = col_from_col_r;
      REG_COL_OFFSET:   prdata = col_offset_r;
      REG_DEN_FROM_ROW: prdata = den_from_row_r;
      REG_DEN_FROM_COL: prdata = den_from_col_r;
      default:          prdata = '0;
    endcase
  end

  // A stage holds only when it and every stage after it are full and the
  // result is not taken, so bubbles close up behind a waiting result.
  for (genvar i = 0; i < NS; i++) begin : g_adv
    assign adv[i] = ~((&stg_vld_r[NS-1:i]) & ~out_tready);
  end

  assign in_tready = adv[0];

  always_comb begin
    stg_vld_nxt[0] = adv[0] ? in_tvalid : stg_vld_r[0];
    for (int i = 1; i < NS; i++) begin
      stg_vld_nxt[i] = adv[i] ? stg_vld_r[i-1] : stg_vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  // Stage 0: the six matrix products.
  assign in_row = in_tdata[COORD_W-1:0];
  assign in_col = in_tdata[IN_TDATA_W-1:COORD_W];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mu_rr_r   <= row_from_row_r * in_row;
      mu_rc_r   <= row_from_col_r * in_col;
      mu_cr_r   <= col_from_row_r * in_row;
      mu_cc_r   <= col_from_col_r * in_col;
      mu_dr_r   <= den_from_row_r * in_row;
      mu_dc_r   <= den_from_col_r * in_col;
      mu_roff_r <= row_offset_r;
      mu_coff_r <= col_offset_r;
    end
  end

  // Stage 1: projective sums, all with 24 fraction bits except the
  // denominator, which carries 36.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      su_rsum_r <= SUM_W'(mu_rr_r) + SUM_W'(mu_rc_r) + (SUM_W'(mu_roff_r) <<< OFF_SHIFT);
      su_csum_r <= SUM_W'(mu_cr_r) + SUM_W'(mu_cc_r) + (SUM_W'(mu_coff_r) <<< OFF_SHIFT);
      su_dsum_r <= SUM_W'(mu_dr_r) + SUM_W'(mu_dc_r) + DEN_ONE;
    end
  end

  // Stage 2: magnitudes and quotient signs for the unsigned divider.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      ab_rmag_r <= su_rsum_r[SUM_W-1] ? SUM_W'(-su_rsum_r) : SUM_W'(su_rsum_r);
      ab_cmag_r <= su_csum_r[SUM_W-1] ? SUM_W'(-su_csum_r) : SUM_W'(su_csum_r);
      ab_dmag_r <= su_dsum_r[SUM_W-1] ? SUM_W'(-su_dsum_r) : SUM_W'(su_dsum_r);
      ab_rneg_r <= su_rsum_r[SUM_W-1] ^ su_dsum_r[SUM_W-1];
      ab_cneg_r <= su_csum_r[SUM_W-1] ^ su_dsum_r[SUM_W-1];
    end
  end

  // Restoring divider, one quotient bit per stage. The first stage checks
  // whether the quotient needs more than QW bits; a zero divisor always
  // fails that check, so it falls out as outside too.
  for (genvar k = 0; k <= QW; k++) begin : g_div
    logic [WW-1:0]    rrem_in, crem_in, dshift;
    logic [SUM_W-1:0] den_in;
    logic [QW-1:0]    rq_in, cq_in;
    logic             rovf_in, covf_in, rneg_in, cneg_in;
    logic             rge, cge;

    if (k == 0) begin : g_first
      assign rrem_in = WW'(ab_rmag_r) << FRAC_SHIFT;
      assign crem_in = WW'(ab_cmag_r) << FRAC_SHIFT;
      assign den_in  = ab_dmag_r;
      assign rq_in   = '0;
      assign cq_in   = '0;
      assign rovf_in = 1'b0;
      assign covf_in = 1'b0;
      assign rneg_in = ab_rneg_r;
      assign cneg_in = ab_cneg_r;
    end else begin : g_next
      assign rrem_in = dv_rrem_r[k-1];
      assign crem_in = dv_crem_r[k-1];
      assign den_in  = dv_den_r[k-1];
      assign rq_in   = dv_rq_r[k-1];
      assign cq_in   = dv_cq_r[k-1];
      assign rovf_in = dv_rovf_r[k-1];
      assign covf_in = dv_covf_r[k-1];
      assign rneg_in = dv_rneg_r[k-1];
      assign cneg_in = dv_cneg_r[k-1];
    end

    assign dshift = WW'(den_in) << (QW - k);
    assign rge    = rrem_in >= dshift;
    assign cge    = crem_in >= dshift;

    always_ff @(posedge clk) begin
      if (adv[ST_DIV+k]) begin
        dv_den_r[k]  <= den_in;
        dv_rneg_r[k] <= rneg_in;
        dv_cneg_r[k] <= cneg_in;
        if (k == 0) begin
          dv_rrem_r[k] <= rrem_in;
          dv_crem_r[k] <= crem_in;
          dv_rq_r[k]   <= rq_in;
          dv_cq_r[k]   <= cq_in;
          dv_rovf_r[k] <= rovf_in | rge;
          dv_covf_r[k] <= covf_in | cge;
        end else begin
          dv_rrem_r[k] <= rge ? (rrem_in - dshift) : rrem_in;
          dv_crem_r[k] <= cge ? (crem_in - dshift) : crem_in;
          dv_rq_r[k]   <= (rq_in << 1) | QW'(rge);
          dv_cq_r[k]   <= (cq_in << 1) | QW'(cge);
          dv_rovf_r[k] <= rovf_in;
          dv_covf_r[k] <= covf_in;
        end
      end
    end
  end

  // Output stage: a negative quotient is inside only when it truncates to
  // zero; anything outside reads as zero coordinates.
  always_comb begin
    row_in = ~dv_rovf_r[QW] & ((dv_rq_r[QW] == '0) |
             (~dv_rneg_r[QW] & ({1'b0, dv_rq_r[QW]} < ROWS_LIM)));
    col_in = ~dv_covf_r[QW] & ((dv_cq_r[QW] == '0) |
             (~dv_cneg_r[QW] & ({1'b0, dv_cq_r[QW]} < COLS_LIM)));
    in_img = row_in & col_in;
    src_row_nxt = in_img ? ROW_W'(dv_rq_r[QW]) : '0;
    src_col_nxt = in_img ? COL_W'(dv_cq_r[QW]) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      src_row_r <= src_row_nxt;
      src_col_r <= src_col_nxt;
      inside_r  <= in_img;
    end
  end

  assign out_tvalid = stg_vld_r[NS-1];
  assign out_tdata  = {(OUT_TDATA_W-ROW_W-COL_W)'(0), src_col_r, src_row_r};
  assign out_tuser  = inside_r;

  // An outside result never carries a coordinate.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("outside result with nonzero coordinates");

  // An accepted item occupies the first stage on the next cycle.
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> stg_vld_r[0])
    else $error("accepted item lost at pipeline entry");

  // Each divider stage leaves a remainder below the divisor at its bit weight.
  for (genvar k = 0; k <= QW; k++) begin : g_chk
    a_row_rem: assert property (@(posedge clk) disable iff (!rst_n)
      (stg_vld_r[ST_DIV+k] && !dv_rovf_r[k]) |->
        (dv_rrem_r[k] < (WW'(dv_den_r[k]) << (QW - k))))
      else $error("row remainder out of bound");
    a_col_rem: assert property (@(posedge clk) disable iff (!rst_n)
      (stg_vld_r[ST_DIV+k] && !dv_covf_r[k]) |->
        (dv_crem_r[k] < (WW'(dv_den_r[k]) << (QW - k))))
      else $error("column remainder out of bound");
  end

endmodule
